// ----- rtl/websocket_frame_decoder_macros.svh -----
// Assertion macros shared by the websocket frame decoder checkers.
// Needs a clk and rst signal in the scope of use.
`ifndef WEBSOCKET_FRAME_DECODER_MACROS_SVH
`define WEBSOCKET_FRAME_DECODER_MACROS_SVH

// checked only outside reset
`define WSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define WSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wsd_pkg.sv -----
// Package for the websocket frame decoder: parser phase type and header constants.
// No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned OFFSET_W = 14;

  // 7-bit length code that announces a 16-bit extended length; the code above it announces a 64-bit one
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LEN7    = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

endpackage

// ----- rtl/wsd_in_if.sv -----
// Input channel of the websocket frame decoder: one stream byte per word.
// No dependencies.
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- rtl/wsd_out_if.sv -----
// Output channel of the websocket frame decoder: one decoded byte per word.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

interface wsd_out_if;
  import wsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                payload_valid;
  logic [OFFSET_W-1:0] payload_offset;
  logic                oversize;
  logic                frame_end;
  logic [3:0]          opcode;
  logic                fin;

  modport source (
    output valid, output out_byte, output payload_valid, output payload_offset,
    output oversize, output frame_end, output opcode, output fin, input ready
  );
  modport sink (
    input valid, input out_byte, input payload_valid, input payload_offset,
    input oversize, input frame_end, input opcode, input fin, output ready
  );
endinterface

// ----- rtl/websocket_frame_decoder.sv -----
// Path: a word passes the input register and then the result register before it leaves.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates in the single step
// between the input and result registers.
// Reset (rst, synchronous): parser back to start of frame, lengths, key and flags cleared,
// both pipeline registers empty. Depends on wsd_pkg, wsd_in_if, wsd_out_if.
`timescale 1ns / 1ps

module websocket_frame_decoder #(
  parameter int unsigned MAX_STORE = 16384
) (
  input logic        clk,
  input logic        rst,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);
  import wsd_pkg::*;

  localparam logic [63:0] STORE_LIMIT = 64'(MAX_STORE);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  phase_t          phase, phase_next;
  logic [2:0]      byte_count, byte_count_next;
  logic [3:0]      frame_opcode, frame_opcode_next;
  logic            frame_fin, frame_fin_next;
  logic            is_masked, is_masked_next;
  logic [63:0]     payload_length, payload_length_next;
  logic [63:0]     payload_position, payload_position_next;
  logic [3:0][7:0] mask_key, mask_key_next;

  logic [2:0]          cnt_inc;
  logic [63:0]         pos_inc;
  logic [7:0]          data;
  logic                store;
  logic [OFFSET_W-1:0] offset;
  logic                over;
  logic                end_flag;

  logic                out_valid;
  logic [7:0]          out_byte;
  logic                payload_valid;
  logic [OFFSET_W-1:0] payload_offset;
  logic                oversize;
  logic                frame_end;
  logic [3:0]          opcode;
  logic                fin;

  assign advance     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !rst && (!s1_valid || !out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.in_byte;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    frame_opcode_next     = frame_opcode;
    frame_fin_next        = frame_fin;
    is_masked_next        = is_masked;
    payload_length_next   = payload_length;
    payload_position_next = payload_position;
    mask_key_next         = mask_key;
    cnt_inc               = byte_count + 3'd1;
    pos_inc               = payload_position + 64'd1;
    data                  = 8'd0;
    store                 = 1'b0;
    offset                = '0;
    over                  = 1'b0;
    end_flag              = 1'b0;

    case (phase)
      PH_LEN7: begin
        is_masked_next  = s1_byte[7];
        byte_count_next = 3'd0;
        if (s1_byte[6:0] < LEN_EXT16) begin
          payload_length_next = {57'd0, s1_byte[6:0]};
          if (s1_byte[7]) begin
            phase_next = PH_MASK;
          end else if (s1_byte[6:0] == 7'd0) begin
            phase_next = PH_START;
            end_flag   = 1'b1;
          end else begin
            payload_position_next = 64'd0;
            phase_next            = PH_PAYLOAD;
          end
        end else begin
          phase_next          = (s1_byte[6:0] == LEN_EXT16) ? PH_LEN16 : PH_LEN64;
          payload_length_next = 64'd0;
        end
      end
      PH_LEN16, PH_LEN64: begin
        payload_length_next = {payload_length[55:0], s1_byte};
        byte_count_next     = cnt_inc;
        if ((phase == PH_LEN16 && cnt_inc == 3'd2) ||
            (phase == PH_LEN64 && cnt_inc == 3'd0)) begin
          byte_count_next = 3'd0;
          if (is_masked) begin
            phase_next = PH_MASK;
          end else if (payload_length_next == 64'd0) begin
            phase_next = PH_START;
            end_flag   = 1'b1;
          end else begin
            payload_position_next = 64'd0;
            phase_next            = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        mask_key_next[byte_count[1:0]] = s1_byte;
        byte_count_next                = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          byte_count_next = 3'd0;
          if (payload_length == 64'd0) begin
            phase_next = PH_START;
            end_flag   = 1'b1;
          end else begin
            payload_position_next = 64'd0;
            phase_next            = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        data = is_masked ? (s1_byte ^ mask_key[payload_position[1:0]]) : s1_byte;
        if (payload_length <= STORE_LIMIT) begin
          store  = 1'b1;
          offset = payload_position[OFFSET_W-1:0];
        end else begin
          over = 1'b1;
        end
        payload_position_next = pos_inc;
        if (pos_inc >= payload_length) begin
          phase_next      = PH_START;
          byte_count_next = 3'd0;
          end_flag        = 1'b1;
        end
      end
      default: begin
        frame_opcode_next = s1_byte[3:0];
        frame_fin_next    = s1_byte[7];
        phase_next        = PH_LEN7;
        byte_count_next   = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      byte_count       <= 3'd0;
      frame_opcode     <= 4'd0;
      frame_fin        <= 1'b0;
      is_masked        <= 1'b0;
      payload_length   <= 64'd0;
      payload_position <= 64'd0;
      mask_key         <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      frame_opcode     <= frame_opcode_next;
      frame_fin        <= frame_fin_next;
      is_masked        <= is_masked_next;
      payload_length   <= payload_length_next;
      payload_position <= payload_position_next;
      mask_key         <= mask_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_byte       <= data;
      payload_valid  <= store;
      payload_offset <= offset;
      oversize       <= over;
      frame_end      <= end_flag;
      opcode         <= frame_opcode_next;
      fin            <= frame_fin_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_byte;
  assign out_ch.payload_valid  = payload_valid;
  assign out_ch.payload_offset = payload_offset;
  assign out_ch.oversize       = oversize;
  assign out_ch.frame_end      = frame_end;
  assign out_ch.opcode         = opcode;
  assign out_ch.fin            = fin;

endmodule

// ----- rtl/wsd_check.sv -----
// Port-level checks for websocket_frame_decoder, attached by the bind at the end.
// Depends on websocket_frame_decoder_macros.svh.
`timescale 1ns / 1ps

`include "websocket_frame_decoder_macros.svh"

module wsd_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        payload_valid,
  input logic [13:0] payload_offset,
  input logic        oversize
);

  `WSD_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !out_valid, "word shown right after reset")
  `WSD_ASSERT(a_store_xor_over, out_valid |-> !(payload_valid && oversize), "stored and oversize together")
  `WSD_ASSERT(a_header_zero, (out_valid && !payload_valid && !oversize) |-> (out_byte == 8'd0), "header word with nonzero byte")
  `WSD_ASSERT(a_offset_zero, (out_valid && !payload_valid) |-> (payload_offset == 14'd0), "offset on unstored word")
  `WSD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)), "stalled word dropped or changed")

endmodule

bind websocket_frame_decoder wsd_check u_wsd_check (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_byte       (out_ch.out_byte),
  .payload_valid  (out_ch.payload_valid),
  .payload_offset (out_ch.payload_offset),
  .oversize       (out_ch.oversize)
);

// ----- bench/wsd_stream_checker.sv -----
// Watches both channels of the websocket frame decoder, predicts each decoded word
// from the accepted stream bytes and compares. Depends on wsd_pkg, wsd_in_if, wsd_out_if.
`timescale 1ns / 1ps

module wsd_stream_checker
  import wsd_pkg::*;
#(
  parameter int unsigned STORE_LIMIT = 16384
) (
  input  logic        clk,
  input  logic        rst,
  wsd_in_if           in_ch,
  wsd_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [7:0]          data;
    logic                store;
    logic [OFFSET_W-1:0] offset;
    logic                over;
    logic                last;
    logic [3:0]          opcode;
    logic                fin;
  } decoded_t;

  phase_t      parse_phase;
  logic [2:0]  hdr_count;
  logic [3:0]  cur_opcode;
  logic        cur_fin;
  logic        masked;
  logic [63:0] frame_len;
  logic [63:0] frame_pos;
  logic [7:0]  key_bytes [4];
  decoded_t    decoded_q [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (mismatches < 40) begin
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report(what, got, want);
    end
  endtask

  function automatic logic open_body();
    hdr_count = '0;
    if (frame_len == 64'd0) begin
      parse_phase = PH_START;
      return 1'b1;
    end
    frame_pos = '0;
    parse_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic logic length_complete();
    if (masked) begin
      parse_phase = PH_MASK;
      hdr_count = '0;
      return 1'b0;
    end
    return open_body();
  endfunction

  function automatic decoded_t decode_byte(input logic [7:0] b);
    decoded_t d;
    d = '0;
    case (parse_phase)
      PH_LEN7: begin
        masked = b[7];
        frame_len = {57'd0, b[6:0]};
        hdr_count = '0;
        if (b[6:0] < LEN_EXT16) begin
          d.last = length_complete();
        end else begin
          if (b[6:0] == LEN_EXT16) begin
            parse_phase = PH_LEN16;
          end else begin
            parse_phase = PH_LEN64;
          end
          frame_len = '0;
        end
      end
      PH_LEN16, PH_LEN64: begin
        frame_len = {frame_len[55:0], b};
        hdr_count = hdr_count + 3'd1;
        if ((parse_phase == PH_LEN16 && hdr_count == 3'd2) ||
            (parse_phase == PH_LEN64 && hdr_count == 3'd0)) begin
          d.last = length_complete();
        end
      end
      PH_MASK: begin
        key_bytes[hdr_count[1:0]] = b;
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= 3'd4) begin
          d.last = open_body();
        end
      end
      PH_PAYLOAD: begin
        d.data = masked ? (b ^ key_bytes[frame_pos[1:0]]) : b;
        if (frame_len <= 64'(STORE_LIMIT)) begin
          d.store = 1'b1;
          d.offset = frame_pos[OFFSET_W-1:0];
        end else begin
          d.over = 1'b1;
        end
        frame_pos = frame_pos + 64'd1;
        if (frame_pos >= frame_len) begin
          parse_phase = PH_START;
          hdr_count = '0;
          d.last = 1'b1;
        end
      end
      default: begin
        cur_opcode = b[3:0];
        cur_fin = b[7];
        parse_phase = PH_LEN7;
        hdr_count = '0;
      end
    endcase
    d.opcode = cur_opcode;
    d.fin = cur_fin;
    return d;
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      parse_phase = PH_START;
      hdr_count = '0;
      cur_opcode = '0;
      cur_fin = 1'b0;
      masked = 1'b0;
      frame_len = '0;
      frame_pos = '0;
      for (int i = 0; i < 4; i++) key_bytes[i] = '0;
      decoded_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decoded_q.push_back(decode_byte(in_ch.in_byte));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          report("unexpected word", 64'(out_ch.out_byte), 64'd0);
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 64'(out_ch.out_byte), 64'(want.data));
          check_field("payload_valid", 64'(out_ch.payload_valid), 64'(want.store));
          check_field("payload_offset", 64'(out_ch.payload_offset), 64'(want.offset));
          check_field("oversize", 64'(out_ch.oversize), 64'(want.over));
          check_field("frame_end", 64'(out_ch.frame_end), 64'(want.last));
          check_field("opcode", 64'(out_ch.opcode), 64'(want.opcode));
          check_field("fin", 64'(out_ch.fin), 64'(want.fin));
        end
      end
    end
    outstanding <= decoded_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the websocket frame decoder bench: clock, reset, byte stream stimulus,
// output backpressure and the verdict. Depends on wsd_pkg, both channel
// interfaces, websocket_frame_decoder and wsd_stream_checker.
`timescale 1ns / 1ps

module testbench;
  import wsd_pkg::*;

  localparam int unsigned STORE_LIMIT = 16384;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;
  localparam int unsigned PHASE_BYTES = 175;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;
  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned outstanding;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  websocket_frame_decoder #(.MAX_STORE(STORE_LIMIT)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wsd_stream_checker #(.STORE_LIMIT(STORE_LIMIT)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (chance(send_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] head, input logic mask_on, input phase_t form,
                            input logic [63:0] len, input int unsigned body);
    send_byte(head);
    case (form)
      PH_LEN16: begin
        send_byte({mask_on, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      PH_LEN64: begin
        send_byte({mask_on, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: begin
        send_byte({mask_on, len[6:0]});
      end
    endcase
    if (mask_on) begin
      repeat (4) send_byte(8'($urandom_range(255)));
    end
    repeat (body) send_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    phase_t form;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        form = PH_LEN7;
        len = (pick < 50) ? $urandom_range(12) : $urandom_range(125);
      end else begin
        form = (pick < 88) ? PH_LEN16 : PH_LEN64;
        len = ($urandom_range(5) == 0) ? $urandom_range(126, 400) : $urandom_range(40);
      end
      send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), form, 64'(len), len);
    end
  endtask

  // output side: random stalls plus a long hold-off whenever hold_requests changes
  initial begin : drain_side
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !chance(stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    bytes_sent = 0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty frames in every length form (masked only in the 7-bit form), then two short frames
    send_frame(8'h81, 1'b0, PH_LEN7, 64'd0, 0);
    send_frame(8'h09, 1'b1, PH_LEN7, 64'd0, 0);
    send_frame(8'h0A, 1'b0, PH_LEN16, 64'd0, 0);
    send_frame(8'h8F, 1'b0, PH_LEN64, 64'd0, 0);
    send_frame(8'h01, 1'b1, PH_LEN7, 64'd3, 3);
    send_frame(8'h82, 1'b0, PH_LEN7, 64'd1, 1);
    run_random(PHASE_BYTES);

    send_idle_pct = 55;
    run_random(PHASE_BYTES);

    send_idle_pct = 0;
    stall_pct = 55;
    hold_requests++;
    run_random(PHASE_BYTES);

    send_idle_pct = 38;
    stall_pct = 38;
    run_random(PHASE_BYTES);
    // top length bit set: stays in payload for the rest of the run
    send_frame(8'h88, 1'b1, PH_LEN64, 64'h8000_0000_0000_0005, 6);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
